// ===== hdl/lbh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbh_pkg
// Shared types, constants and helpers for the byte and line length
// histogram unit.
// ----------------------------------------------------------------------------
package lbh_pkg;

  localparam int DEF_LENGTH_BINS = 1024;
  localparam int DEF_COUNT_WIDTH = 40;

  localparam int          BYTE_VALUES  = 256;
  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam int          OUT_W        = 40;
  localparam logic [63:0] OUT_MAX      = 64'h0000_00FF_FFFF_FFFF;

  localparam int IN_TDATA_W  = 24;
  localparam int RES_W       = 4 * OUT_W + 9 + 1;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_RD_BYTE = 2'd2,
    KIND_RD_LEN  = 2'd3
  } lbh_kind_t;

  typedef struct packed {
    logic [10:0] bin_index;
    logic [7:0]  data_byte;
    lbh_kind_t   kind;
  } lbh_item_t;

  // first member sits in the top bits, so total_lines lands at bit 0
  typedef struct packed {
    logic [OUT_W-1:0] bin_value;
    logic             newline_seen;
    logic [8:0]       alphabet_size;
    logic [OUT_W-1:0] length_total;
    logic [OUT_W-1:0] total_bytes;
    logic [OUT_W-1:0] total_lines;
  } lbh_result_t;

  typedef struct packed {
    logic res_valid;
    logic len_rd;
    logic len_upd;
  } lbh_s2_ctl_t;

  // clamp a count to the 40-bit output range
  function automatic logic [OUT_W-1:0] out_sat(input logic [63:0] v);
    return (v > OUT_MAX) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/byte_and_line_length_histogram_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_and_line_length_histogram_unit
// Byte value histogram with a line length histogram and stream totals.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_tready is high. Data bytes produce no
// result; end, byte bin read and length bin read words each produce one
// result word, in order, which passes the byte stage register, the length
// stage register and the result queue before it is valid on the output.
// The rate is set by the byte bin RAM: its read is issued on acceptance,
// the incremented count is written back in the next cycle, and a register
// forwards that write to the following word, so repeated bytes still go at
// one per clock. Line closes update the length bin RAM the same way in the
// length stage. A four-entry result queue absorbs output stalls; in_tready
// also drops when the queue and the result words in flight fill it. After
// reset both RAMs are zeroed, one entry per clock, with in_tready low.
// ----------------------------------------------------------------------------
module byte_and_line_length_histogram_unit #(
  parameter int LENGTH_BINS = lbh_pkg::DEF_LENGTH_BINS,
  parameter int COUNT_WIDTH = lbh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [7:0] data_byte, [18:8] bin_index, [23:19] zero
  input  wire logic [lbh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [39:0] total_lines, [79:40] total_bytes, [119:80] length_total,
  // [128:120] alphabet_size, [129] newline_seen, [169:130] bin_value,
  // [175:170] zero
  output logic [lbh_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int LADDR_W   = $clog2(LENGTH_BINS + 1);
  localparam int CLR_DEPTH = (LENGTH_BINS + 1 > lbh_pkg::BYTE_VALUES) ? LENGTH_BINS + 1
                                                                      : lbh_pkg::BYTE_VALUES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int CNT_W     = lbh_pkg::OUT_FIFO_CNT_W;
  localparam int OCC_W     = CNT_W + 1;

  logic               clr_active_r;
  logic [CLR_W-1:0]   clr_cnt_r;
  logic               clr_byte_we, clr_len_we;

  lbh_pkg::lbh_item_t   item;
  logic                 acc;
  logic                 s1_pending, s2_busy;
  lbh_pkg::lbh_s2_ctl_t s2_ctl;
  logic [LADDR_W-1:0]   s2_laddr;
  lbh_pkg::lbh_result_t s2_res;
  logic                 push;
  lbh_pkg::lbh_result_t push_data, head;
  logic [CNT_W-1:0]     fifo_cnt;
  logic [OCC_W-1:0]     occ;

  // zeroing sweep over both RAMs after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  assign clr_byte_we = clr_active_r && (32'(clr_cnt_r) < 32'(lbh_pkg::BYTE_VALUES));
  assign clr_len_we  = clr_active_r && (32'(clr_cnt_r) <= 32'(LENGTH_BINS));

  assign item.kind      = lbh_pkg::lbh_kind_t'(in_tuser);
  assign item.data_byte = in_tdata[7:0];
  assign item.bin_index = in_tdata[18:8];

  // results already on their way must all find room in the queue
  assign occ       = OCC_W'(fifo_cnt) + OCC_W'(s1_pending) + OCC_W'(s2_busy);
  assign in_tready = !clr_active_r && (occ < OCC_W'(lbh_pkg::OUT_FIFO_DEPTH));
  assign acc       = in_tvalid && in_tready;

  lbh_byte_stage #(.LENGTH_BINS(LENGTH_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_byte_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_we     (clr_byte_we),
    .clr_addr   (clr_cnt_r[7:0]),
    .acc        (acc),
    .item       (item),
    .s1_pending (s1_pending),
    .s2_ctl     (s2_ctl),
    .s2_laddr   (s2_laddr),
    .s2_res     (s2_res)
  );

  lbh_len_stage #(.LENGTH_BINS(LENGTH_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_len_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_we    (clr_len_we),
    .clr_addr  (clr_cnt_r[LADDR_W-1:0]),
    .s2_ctl    (s2_ctl),
    .s2_laddr  (s2_laddr),
    .s2_res    (s2_res),
    .s2_busy   (s2_busy),
    .push      (push),
    .push_data (push_data)
  );

  lbh_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (out_tready),
    .not_empty (out_tvalid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_tdata = {(lbh_pkg::OUT_TDATA_W - lbh_pkg::RES_W)'(0), head};

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OCC_W'(lbh_pkg::OUT_FIFO_DEPTH))
    else $error("result words in flight exceed queue room");

endmodule
`default_nettype wire

// ===== hdl/lbh_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbh_ram
// Generic simple dual-port RAM, one write port, one registered read port,
// read-first on a same-address collision.
// ----------------------------------------------------------------------------
module lbh_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lbh_byte_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbh_byte_stage
// Byte bin read-modify-write with forwarding, plus the line, byte and
// alphabet bookkeeping; issues the length bin access for the next stage.
// ----------------------------------------------------------------------------
module lbh_byte_stage #(
  parameter int LENGTH_BINS = lbh_pkg::DEF_LENGTH_BINS,
  parameter int COUNT_WIDTH = lbh_pkg::DEF_COUNT_WIDTH,
  localparam int LADDR_W = $clog2(LENGTH_BINS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  clr_we,
  input  wire logic [7:0]            clr_addr,
  input  wire logic                  acc,
  input  wire lbh_pkg::lbh_item_t    item,
  output logic                       s1_pending,
  output lbh_pkg::lbh_s2_ctl_t       s2_ctl,
  output logic [LADDR_W-1:0]         s2_laddr,
  output lbh_pkg::lbh_result_t       s2_res
);

  localparam int CW = COUNT_WIDTH;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  logic               s1_valid_r;
  lbh_pkg::lbh_item_t s1_item_r;
  logic [7:0]         s1_addr_r;
  logic [7:0]         raddr;

  logic [CW-1:0] ram_q, bval, bval_inc;
  logic          lw_valid_r;
  logic [7:0]    lw_addr_r;
  logic [CW-1:0] lw_data_r;

  logic [CW-1:0] cur_len_r, cur_len_nxt;
  logic [CW-1:0] lines_r, lines_nxt;
  logic [CW-1:0] bytes_r, bytes_nxt;
  logic [CW-1:0] lsum_r, lsum_nxt;
  logic [8:0]    distinct_r, distinct_nxt;
  logic          nl_seen_r, nl_seen_nxt;
  logic          closed_r, closed_nxt;

  logic [CW:0]   lsum_add;
  logic          do_data, close;
  logic          b_we;
  logic [7:0]    b_waddr;
  logic [CW-1:0] b_wdata;

  assign raddr = (item.kind == lbh_pkg::KIND_DATA) ? item.data_byte : item.bin_index[7:0];

  lbh_ram #(.WIDTH(CW), .DEPTH(lbh_pkg::BYTE_VALUES)) u_byte_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      lw_valid_r <= do_data;
    end
    s1_item_r <= item;
    s1_addr_r <= raddr;
    lw_addr_r <= s1_addr_r;
    lw_data_r <= bval_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r  <= '0;
      lines_r    <= '0;
      bytes_r    <= '0;
      lsum_r     <= '0;
      distinct_r <= '0;
      nl_seen_r  <= 1'b0;
      closed_r   <= 1'b0;
    end else begin
      cur_len_r  <= cur_len_nxt;
      lines_r    <= lines_nxt;
      bytes_r    <= bytes_nxt;
      lsum_r     <= lsum_nxt;
      distinct_r <= distinct_nxt;
      nl_seen_r  <= nl_seen_nxt;
      closed_r   <= closed_nxt;
    end
  end

  // the previous cycle's write has not reached the RAM output yet
  assign bval     = (lw_valid_r && lw_addr_r == s1_addr_r) ? lw_data_r : ram_q;
  assign bval_inc = sat_inc(bval);
  assign lsum_add = {1'b0, lsum_r} + {1'b0, cur_len_r};

  always_comb begin
    cur_len_nxt  = cur_len_r;
    lines_nxt    = lines_r;
    bytes_nxt    = bytes_r;
    lsum_nxt     = lsum_r;
    distinct_nxt = distinct_r;
    nl_seen_nxt  = nl_seen_r;
    closed_nxt   = closed_r;
    do_data      = 1'b0;
    close        = 1'b0;
    s2_ctl       = '0;
    s2_res       = '0;
    s2_laddr     = LADDR_W'(s1_item_r.bin_index);

    if (s1_valid_r) begin
      case (s1_item_r.kind)
        lbh_pkg::KIND_DATA: begin
          if (!closed_r) begin
            do_data   = 1'b1;
            bytes_nxt = sat_inc(bytes_r);
            if (bval == '0 && !distinct_r[8]) begin
              distinct_nxt = distinct_r + 9'd1;
            end
            if (s1_item_r.data_byte == lbh_pkg::NEWLINE_BYTE) begin
              close       = 1'b1;
              nl_seen_nxt = 1'b1;
            end else begin
              cur_len_nxt = sat_inc(cur_len_r);
            end
          end
        end
        lbh_pkg::KIND_END: begin
          s2_ctl.res_valid = 1'b1;
          close            = !closed_r;
          closed_nxt       = 1'b1;
        end
        lbh_pkg::KIND_RD_BYTE: begin
          s2_ctl.res_valid = 1'b1;
          if (s1_item_r.bin_index[10:8] == 3'd0) begin
            s2_res.bin_value = lbh_pkg::out_sat(64'(bval));
          end
        end
        lbh_pkg::KIND_RD_LEN: begin
          s2_ctl.res_valid = 1'b1;
          s2_ctl.len_rd    = 32'(s1_item_r.bin_index) <= 32'(LENGTH_BINS);
        end
        default: ;
      endcase
    end

    if (close) begin
      lines_nxt   = sat_inc(lines_r);
      lsum_nxt    = lsum_add[CW] ? {CW{1'b1}} : lsum_add[CW-1:0];
      cur_len_nxt = '0;
      // long lines share the last bin
      s2_laddr    = (64'(cur_len_r) < 64'(LENGTH_BINS)) ? LADDR_W'(cur_len_r)
                                                        : LADDR_W'(LENGTH_BINS);
    end
    s2_ctl.len_upd = close;

    if (s1_valid_r && s1_item_r.kind == lbh_pkg::KIND_END) begin
      s2_res.total_lines   = lbh_pkg::out_sat(64'(lines_nxt));
      s2_res.total_bytes   = lbh_pkg::out_sat(64'(bytes_nxt));
      s2_res.length_total  = lbh_pkg::out_sat(64'(lsum_nxt));
      s2_res.alphabet_size = distinct_nxt;
      s2_res.newline_seen  = nl_seen_nxt;
    end
  end

  assign b_we    = clr_we || do_data;
  assign b_waddr = clr_we ? clr_addr : s1_addr_r;
  assign b_wdata = clr_we ? '0 : bval_inc;

  assign s1_pending = s1_valid_r && (s1_item_r.kind != lbh_pkg::KIND_DATA);

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("stream closed flag dropped");

  a_close_by_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(closed_r) |-> $past(s1_valid_r && s1_item_r.kind == lbh_pkg::KIND_END))
    else $error("stream closed without an end word");

  a_no_count_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> $stable(bytes_r))
    else $error("byte total moved after end of stream");

endmodule
`default_nettype wire

// ===== hdl/lbh_len_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbh_len_stage
// Length bin read-modify-write with forwarding and length bin reads;
// hands finished results to the output queue.
// ----------------------------------------------------------------------------
module lbh_len_stage #(
  parameter int LENGTH_BINS = lbh_pkg::DEF_LENGTH_BINS,
  parameter int COUNT_WIDTH = lbh_pkg::DEF_COUNT_WIDTH,
  localparam int LADDR_W = $clog2(LENGTH_BINS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  clr_we,
  input  wire logic [LADDR_W-1:0]    clr_addr,
  input  wire lbh_pkg::lbh_s2_ctl_t  s2_ctl,
  input  wire logic [LADDR_W-1:0]    s2_laddr,
  input  wire lbh_pkg::lbh_result_t  s2_res,
  output logic                       s2_busy,
  output logic                       push,
  output lbh_pkg::lbh_result_t       push_data
);

  localparam int CW = COUNT_WIDTH;

  lbh_pkg::lbh_s2_ctl_t ctl_r;
  logic [LADDR_W-1:0]   laddr_r;
  lbh_pkg::lbh_result_t res_r;

  logic [CW-1:0]      ram_q, lval, lval_inc;
  logic               lw_valid_r;
  logic [LADDR_W-1:0] lw_addr_r;
  logic [CW-1:0]      lw_data_r;

  logic               l_we;
  logic [LADDR_W-1:0] l_waddr;
  logic [CW-1:0]      l_wdata;

  lbh_ram #(.WIDTH(CW), .DEPTH(LENGTH_BINS + 1)) u_len_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (s2_laddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r      <= '0;
      lw_valid_r <= 1'b0;
    end else begin
      ctl_r      <= s2_ctl;
      lw_valid_r <= ctl_r.len_upd;
    end
    laddr_r   <= s2_laddr;
    res_r     <= s2_res;
    lw_addr_r <= laddr_r;
    lw_data_r <= lval_inc;
  end

  assign lval     = (lw_valid_r && lw_addr_r == laddr_r) ? lw_data_r : ram_q;
  assign lval_inc = (lval == {CW{1'b1}}) ? lval : lval + CW'(1);

  assign l_we    = clr_we || ctl_r.len_upd;
  assign l_waddr = clr_we ? clr_addr : laddr_r;
  assign l_wdata = clr_we ? '0 : lval_inc;

  always_comb begin
    push_data = res_r;
    if (ctl_r.len_rd) begin
      push_data.bin_value = lbh_pkg::out_sat(64'(lval));
    end
  end

  assign push    = ctl_r.res_valid;
  assign s2_busy = ctl_r.res_valid;

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.len_rd |-> (ctl_r.res_valid && !ctl_r.len_upd))
    else $error("length bin read without a result word");

endmodule
`default_nettype wire

// ===== hdl/lbh_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbh_out_fifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module lbh_out_fifo (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   push,
  input  wire lbh_pkg::lbh_result_t                   push_data,
  input  wire logic                                   pop,
  output logic                                        not_empty,
  output lbh_pkg::lbh_result_t                        head,
  output logic [lbh_pkg::OUT_FIFO_CNT_W-1:0]          count
);

  localparam int DEPTH = lbh_pkg::OUT_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = lbh_pkg::OUT_FIFO_CNT_W;

  lbh_pkg::lbh_result_t q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = q_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule
`default_nettype wire
